// ===== rtl/fss_pkg.sv =====
// Frame slot free stack: shared types, widths and status codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int SIZE_W = 29;
    localparam int OFF_W  = 32;
    localparam int ST_W   = 3;

    typedef logic [ST_W-1:0] t_status;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_EXHAUSTED  = 3'd1;
    localparam t_status ST_BELOW      = 3'd2;
    localparam t_status ST_MISALIGNED = 3'd3;
    localparam t_status ST_PAST       = 3'd4;
    localparam t_status ST_DOUBLE     = 3'd5;

    // Start request to the shared divide/multiply unit.
    typedef struct packed {
        logic start;
        logic mul;
    } t_du_ctl;

    // Write request to the slot stack.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } t_stk_wr;

endpackage

`default_nettype wire

// ===== rtl/fss_divmul.sv =====
// Shared add/subtract unit stepping a restoring divide or a shift-add multiply.
// Depends on fss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fss_divmul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire fss_pkg::t_du_ctl           i_ctl,
    input  wire logic [fss_pkg::OFF_W-1:0]  i_dividend,
    input  wire logic [fss_pkg::IDX_W-1:0]  i_multiplier,
    input  wire logic [fss_pkg::SIZE_W-1:0] i_size,
    output logic                            o_done,
    output logic [fss_pkg::OFF_W-1:0]       o_result,
    output logic                            o_rem_zero
);
    import fss_pkg::*;

    localparam int STEP_W = 5;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic              r_mul, n_mul;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [OFF_W-1:0]  r_q, n_q;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [IDX_W-1:0]  r_m, n_m;

    logic [SIZE_W:0]   shifted;
    logic [OFF_W:0]    op_a, op_b, sum;

    // One 33-bit adder serves both operations.
    always_comb begin
        shifted = {r_rem, r_q[OFF_W-1]};
        if (r_mul) begin
            op_a = {1'b0, r_q[OFF_W-2:0], 1'b0};
            op_b = r_m[IDX_W-1] ? {{(OFF_W+1-SIZE_W){1'b0}}, i_size} : '0;
            sum  = op_a + op_b;
        end else begin
            op_a = {{(OFF_W-SIZE_W){1'b0}}, shifted};
            op_b = {{(OFF_W+1-SIZE_W){1'b0}}, i_size};
            sum  = op_a - op_b;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_mul  = r_mul;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_m    = r_m;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_mul  = i_ctl.mul;
            n_cnt  = i_ctl.mul ? STEP_W'(IDX_W - 1) : STEP_W'(OFF_W - 1);
            n_q    = i_ctl.mul ? '0 : i_dividend;
            n_rem  = '0;
            n_m    = i_multiplier;
        end else if (r_busy) begin
            if (r_mul) begin
                n_q = sum[OFF_W-1:0];
                n_m = {r_m[IDX_W-2:0], 1'b0};
            end else begin
                // no borrow: the trial subtraction fits
                n_q   = {r_q[OFF_W-2:0], ~sum[OFF_W]};
                n_rem = sum[OFF_W] ? shifted[SIZE_W-1:0] : sum[SIZE_W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_mul <= n_mul;
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_m   <= n_m;
    end

    assign o_done     = r_done;
    assign o_result   = r_q;
    assign o_rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

// ===== rtl/fss_stack.sv =====
// Storage for the free slot indices, reset to entry i holding index i.
// Depends on fss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fss_stack (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire fss_pkg::t_stk_wr          i_wr,
    input  wire logic [fss_pkg::IDX_W-1:0] i_rd_addr,
    output logic [fss_pkg::IDX_W-1:0]      o_rd_data
);
    import fss_pkg::*;

    logic [IDX_W-1:0] r_ent [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_ent[k] <= IDX_W'(k);
            end
        end else if (i_wr.we) begin
            r_ent[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_ent[i_rd_addr];

endmodule

`default_nettype wire

// ===== rtl/frame_slot_free_stack_top.sv =====
// Top level of the frame slot free stack: sequencer, stack pointer, result register.
// Depends on fss_pkg, fss_divmul and fss_stack.
`timescale 1ns / 1ps
`default_nettype none

// Allocator for 16 equal-size frame slots, kept as a stack of free slot
// indices (all free after reset, slot 15 on top). Action 0 pops a slot and
// returns its byte offset index * slot size (low 32 bits); action 1 releases
// a byte offset and checks, in order, for a negative offset, misalignment,
// an index past the pool and a slot that is already free, pushing the index
// only if all pass. Any error returns index 0 and offset 0 and leaves the
// state unchanged. One item is processed at a time; o_in_stall is high from
// the transfer until the sequencer is back in idle. An acquire runs 4 multiply
// steps on the shared adder, then picks up the product and loads the output
// register; a release runs 32 restoring divide steps on the same adder, checks
// the quotient, scans up to 16 stack entries, one per cycle, and loads the
// output register. A negative offset or an exhausted pool goes straight to
// loading the output register. The result sits in an output register, so a
// stalled result only holds the sequencer once it has the next one ready. A
// slot size of 0 acts as 1; write it only while the block is idle.
module frame_slot_free_stack_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [fss_pkg::SIZE_W-1:0]  i_cfg_data,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_action,
    input  wire logic signed [fss_pkg::OFF_W:0] i_byte_offset,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [fss_pkg::ST_W-1:0]         o_status,
    output logic [fss_pkg::IDX_W-1:0]        o_slot_index,
    output logic [fss_pkg::OFF_W-1:0]        o_slot_offset,
    output logic [fss_pkg::CNT_W-1:0]        o_free_count
);
    import fss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_top, n_top;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [SIZE_W-1:0] r_slot_size;

    // pending result, waiting for the output register
    t_status           r_res_st, n_res_st;
    logic [IDX_W-1:0]  r_res_idx, n_res_idx;
    logic [OFF_W-1:0]  r_res_off, n_res_off;

    // output register
    logic              r_o_valid, n_o_valid;
    t_status           r_o_st, n_o_st;
    logic [IDX_W-1:0]  r_o_idx, n_o_idx;
    logic [OFF_W-1:0]  r_o_off, n_o_off;
    logic [CNT_W-1:0]  r_o_cnt, n_o_cnt;

    logic              in_xfer;
    logic [SIZE_W-1:0] eff_size;
    t_du_ctl           du_ctl;
    logic              du_done, du_rem_zero;
    logic [OFF_W-1:0]  du_result;
    t_stk_wr           stk_wr;
    logic [IDX_W-1:0]  stk_rd_addr, stk_rd_data;
    logic [CNT_W-1:0]  top_m1;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign eff_size = (r_slot_size == '0) ? SIZE_W'(1) : r_slot_size;
    assign top_m1   = r_top - 1'b1;

    // Pop reads below the top; the scan walks from the bottom.
    assign stk_rd_addr = (r_state == S_SRCH) ? r_i[IDX_W-1:0] : top_m1[IDX_W-1:0];

    fss_divmul u_divmul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (du_ctl),
        .i_dividend   (i_byte_offset[OFF_W-1:0]),
        .i_multiplier (stk_rd_data),
        .i_size       (eff_size),
        .o_done       (du_done),
        .o_result     (du_result),
        .o_rem_zero   (du_rem_zero)
    );

    fss_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (stk_wr),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_top     = r_top;
        n_i       = r_i;
        n_idx     = r_idx;
        n_res_st  = r_res_st;
        n_res_idx = r_res_idx;
        n_res_off = r_res_off;
        n_o_valid = r_o_valid;
        n_o_st    = r_o_st;
        n_o_idx   = r_o_idx;
        n_o_off   = r_o_off;
        n_o_cnt   = r_o_cnt;
        du_ctl    = '0;
        stk_wr    = '0;

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_st  = ST_OK;
                    n_res_idx = '0;
                    n_res_off = '0;
                    if (!i_action) begin
                        if (r_top == '0) begin
                            n_res_st = ST_EXHAUSTED;
                            n_state  = S_OUT;
                        end else begin
                            n_top      = top_m1;
                            n_idx      = stk_rd_data;
                            du_ctl.start = 1'b1;
                            du_ctl.mul   = 1'b1;
                            n_state    = S_MUL;
                        end
                    end else if (i_byte_offset[OFF_W]) begin
                        n_res_st = ST_BELOW;
                        n_state  = S_OUT;
                    end else begin
                        du_ctl.start = 1'b1;
                        n_state      = S_DIV;
                    end
                end
            end
            S_MUL: begin
                if (du_done) begin
                    n_res_idx = r_idx;
                    n_res_off = du_result;
                    n_state   = S_OUT;
                end
            end
            S_DIV: begin
                if (du_done) begin
                    if (!du_rem_zero) begin
                        n_res_st = ST_MISALIGNED;
                        n_state  = S_OUT;
                    end else if (du_result[OFF_W-1:IDX_W] != '0) begin
                        n_res_st = ST_PAST;
                        n_state  = S_OUT;
                    end else begin
                        n_idx   = du_result[IDX_W-1:0];
                        n_i     = '0;
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (r_i >= r_top) begin
                    // not found among the free entries: push it
                    if (r_top < CNT_W'(SLOTS)) begin
                        stk_wr.we   = 1'b1;
                        stk_wr.addr = r_top[IDX_W-1:0];
                        stk_wr.data = r_idx;
                        n_top       = r_top + 1'b1;
                    end
                    n_res_idx = r_idx;
                    n_state   = S_OUT;
                end else if (stk_rd_data == r_idx) begin
                    n_res_st = ST_DOUBLE;
                    n_state  = S_OUT;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_OUT: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid = 1'b1;
                    n_o_st    = r_res_st;
                    n_o_idx   = r_res_idx;
                    n_o_off   = r_res_off;
                    n_o_cnt   = r_top;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top       <= CNT_W'(SLOTS);
            r_o_valid   <= 1'b0;
            r_slot_size <= SIZE_W'(1);
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slot_size <= i_cfg_data;
            end
        end
        r_i       <= n_i;
        r_idx     <= n_idx;
        r_res_st  <= n_res_st;
        r_res_idx <= n_res_idx;
        r_res_off <= n_res_off;
        r_o_st    <= n_o_st;
        r_o_idx   <= n_o_idx;
        r_o_off   <= n_o_off;
        r_o_cnt   <= n_o_cnt;
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_st;
    assign o_slot_index  = r_o_idx;
    assign o_slot_offset = r_o_off;
    assign o_free_count  = r_o_cnt;

endmodule

`default_nettype wire

// ===== rtl/fss_checker.sv =====
// Port-level checks for the frame slot free stack, bound to its top level.
// Depends on fss_pkg and frame_slot_free_stack_top.
`timescale 1ns / 1ps
`default_nettype none

module fss_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [fss_pkg::ST_W-1:0]   o_status,
    input wire logic [fss_pkg::IDX_W-1:0]  o_slot_index,
    input wire logic [fss_pkg::OFF_W-1:0]  o_slot_offset,
    input wire logic [fss_pkg::CNT_W-1:0]  o_free_count
);
    import fss_pkg::*;

    // one item at a time: busy right after a transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous item in flight");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_slot_index == '0 && o_slot_offset == '0))
        else $error("error result carries index or offset");

    a_exhausted_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EXHAUSTED) |-> (o_free_count == '0))
        else $error("exhausted with free slots left");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_slot_index)
             && $stable(o_slot_offset) && $stable(o_free_count)))
        else $error("stalled result changed");

endmodule

bind frame_slot_free_stack_top fss_checker u_fss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_slot_index  (o_slot_index),
    .o_slot_offset (o_slot_offset),
    .o_free_count  (o_free_count)
);

`default_nettype wire
